[hw/rtl/mpt_pkg.sv]
`timescale 1ns / 1ps

package mpt_pkg;

   localparam int PRICE_FIELD_BITS = 32;
   localparam int SLOT_BITS        = 16;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 64;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DIRECTION        = 3'd0,
      CSR_STOP_LOSS_OFFSET = 3'd1,
      CSR_LEVEL_COUNT      = 3'd2,
      CSR_INTERVAL_WORDS   = 3'd3,
      CSR_PROFIT_WORDS     = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_OPENED      = 3'd1,
      EV_ADDED       = 3'd2,
      EV_STOP_LOSS   = 3'd3,
      EV_STOP_PROFIT = 3'd4
   } event_type;

   typedef struct packed {
      logic                        kind;
      logic [PRICE_FIELD_BITS-1:0] bid_price;
      logic [PRICE_FIELD_BITS-1:0] ask_price;
   } req_type;

   typedef struct packed {
      event_type  event_code;
      logic [2:0] level_now;
      logic       position_active;
   } rsp_type;

   typedef struct packed {
      logic                   direction;
      logic [SLOT_BITS-1:0]   stop_loss_offset;
      logic [2:0]             level_count;
      logic [4*SLOT_BITS-1:0] interval_words;
      logic [4*SLOT_BITS-1:0] profit_words;
   } cfg_type;

endpackage

[hw/rtl/mpt_csr.sv]
`timescale 1ns / 1ps

module mpt_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [mpt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mpt_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output mpt_pkg::cfg_type                     cfg_ff
);

   mpt_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (mpt_pkg::csr_index_type'(csr_index))
            mpt_pkg::CSR_DIRECTION: begin
               cfg_in.direction = csr_data[0];
            end
            mpt_pkg::CSR_STOP_LOSS_OFFSET: begin
               cfg_in.stop_loss_offset = csr_data[mpt_pkg::SLOT_BITS-1:0];
            end
            mpt_pkg::CSR_LEVEL_COUNT: begin
               cfg_in.level_count = csr_data[2:0];
            end
            mpt_pkg::CSR_INTERVAL_WORDS: begin
               cfg_in.interval_words = csr_data[4*mpt_pkg::SLOT_BITS-1:0];
            end
            mpt_pkg::CSR_PROFIT_WORDS: begin
               cfg_in.profit_words = csr_data[4*mpt_pkg::SLOT_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.direction        <= 1'b0;
         cfg_ff.stop_loss_offset <= '0;
         cfg_ff.level_count      <= 3'd1;
         cfg_ff.interval_words   <= '0;
         cfg_ff.profit_words     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/mpt_engine.sv]
`timescale 1ns / 1ps

module mpt_engine #(
   parameter int MAX_LEVELS  = 4,
   parameter int PRICE_BITS  = 32,
   parameter int OFFSET_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  mpt_pkg::cfg_type cfg,
   input  logic             fire,
   input  mpt_pkg::req_type item,
   output mpt_pkg::rsp_type rsp_ff
);

   localparam int LVL_BITS = $clog2(MAX_LEVELS + 1);
   localparam logic [2:0] LC_MAX = 3'(MAX_LEVELS);

   typedef logic [PRICE_BITS-1:0] price_type;

   function automatic price_type sat_add(price_type a, price_type b);
      logic [PRICE_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[PRICE_BITS] ? {PRICE_BITS{1'b1}} : s[PRICE_BITS-1:0];
   endfunction

   function automatic price_type sat_sub(price_type a, price_type b);
      return (a > b) ? (a - b) : '0;
   endfunction

   function automatic price_type slot(logic [4*mpt_pkg::SLOT_BITS-1:0] words,
                                       logic [2:0] i);
      logic [OFFSET_BITS-1:0] v;
      v = words[i[1:0]*mpt_pkg::SLOT_BITS +: OFFSET_BITS];
      return PRICE_BITS'(v);
   endfunction

   logic                active_ff, active_in;
   logic [LVL_BITS-1:0] level_ff, level_in;
   price_type           ref_ff, ref_in;
   price_type           next_add_ff, next_add_in;
   price_type           next_profit_ff, next_profit_in;
   price_type           loss_ff, loss_in;
   mpt_pkg::rsp_type    rsp_in;

   logic                sell;
   price_type           bid, ask;
   logic [2:0]          n3, lvl3, adv_idx3;
   price_type           adv_ref, add_iv, prof_iv, last_add, open_ref;
   logic                do_advance, all_used, hit_loss, hit_add, hit_profit;
   mpt_pkg::event_type  ev;

   always_comb begin
      sell = cfg.direction;
      bid  = price_type'(64'(item.bid_price));
      ask  = price_type'(64'(item.ask_price));
      lvl3 = 3'(level_ff);

      if (cfg.level_count == 3'd0) begin
         n3 = 3'd1;
      end else if (cfg.level_count > LC_MAX) begin
         n3 = LC_MAX;
      end else begin
         n3 = cfg.level_count;
      end

      open_ref = sell ? bid : ask;
      all_used = lvl3 >= n3;
      hit_loss = all_used && (sell ? (loss_ff <= ask) : (loss_ff >= bid));
      hit_add  = !all_used && (sell ? (bid >= next_add_ff) : (ask <= next_add_ff));
      hit_profit = sell ? (ask <= next_profit_ff) : (bid >= next_profit_ff);

      active_in      = active_ff;
      level_in       = level_ff;
      ref_in         = ref_ff;
      next_add_in    = next_add_ff;
      next_profit_in = next_profit_ff;
      loss_in        = loss_ff;
      ev             = mpt_pkg::EV_NONE;
      do_advance     = 1'b0;

      if (item.kind) begin
         ref_in     = open_ref;
         loss_in    = sell ? sat_add(open_ref, PRICE_BITS'(cfg.stop_loss_offset))
                           : sat_sub(open_ref, PRICE_BITS'(cfg.stop_loss_offset));
         active_in  = 1'b1;
         do_advance = 1'b1;
         ev         = mpt_pkg::EV_OPENED;
      end else if (active_ff) begin
         if (hit_loss) begin
            active_in = 1'b0;
            ev        = mpt_pkg::EV_STOP_LOSS;
         end else if (hit_add) begin
            do_advance = 1'b1;
            ev         = mpt_pkg::EV_ADDED;
         end else if (hit_profit) begin
            active_in = 1'b0;
            ev        = mpt_pkg::EV_STOP_PROFIT;
         end
      end

      // shared level advance: open starts at level zero from the new reference
      adv_idx3 = item.kind ? 3'd0 : lvl3;
      adv_ref  = item.kind ? open_ref : ref_ff;
      add_iv   = slot(cfg.interval_words, adv_idx3 + 3'd1);
      prof_iv  = slot(cfg.profit_words, adv_idx3);
      last_add = sell ? sat_add(adv_ref, slot(cfg.interval_words, adv_idx3))
                      : sat_sub(adv_ref, slot(cfg.interval_words, adv_idx3));
      if (do_advance) begin
         if ((adv_idx3 + 3'd1) < n3) begin
            next_add_in = sell ? sat_add(adv_ref, add_iv) : sat_sub(adv_ref, add_iv);
         end
         if (adv_idx3 < n3) begin
            next_profit_in = sell ? sat_sub(last_add, prof_iv) : sat_add(last_add, prof_iv);
         end
         level_in = LVL_BITS'(adv_idx3 + 3'd1);
      end

      rsp_in.event_code      = ev;
      rsp_in.level_now       = 3'(level_in);
      rsp_in.position_active = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         level_ff       <= '0;
         ref_ff         <= '0;
         next_add_ff    <= '0;
         next_profit_ff <= '0;
         loss_ff        <= '0;
      end else if (fire) begin
         active_ff      <= active_in;
         level_ff       <= level_in;
         ref_ff         <= ref_in;
         next_add_ff    <= next_add_in;
         next_profit_ff <= next_profit_in;
         loss_ff        <= loss_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[hw/rtl/martingale_position_tracker.sv]
`timescale 1ns / 1ps
// flow: a beat accepted is held in the input register until the engine fires,
//   then its result is registered in the result register and shown on rsp_ from then on
// throughput: one tick per cycle while rsp_stall is not holding a valid result
// reset: synchronous, active high; clears pipeline valids, position state
//   and configuration (level count resets to one)

module martingale_position_tracker #(
   parameter int MAX_LEVELS  = 4,
   parameter int PRICE_BITS  = 32,
   parameter int OFFSET_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mpt_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mpt_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write_enable,
   input  logic [mpt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mpt_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   logic             in_valid_ff, in_valid_in;
   mpt_pkg::req_type in_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             advance, fire, load;
   mpt_pkg::cfg_type cfg;

   mpt_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg_ff           (cfg)
   );

   mpt_engine #(
      .MAX_LEVELS  (MAX_LEVELS),
      .PRICE_BITS  (PRICE_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (fire),
      .item   (in_data_ff),
      .rsp_ff (rsp_data)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign load      = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (load) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_data_ff <= req_data;
      end
   end

endmodule
